>>> design/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants and types of the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int EPS_W     = 16;
	localparam int AXES      = 3;
	localparam int LANES     = 2 * AXES;
	localparam int DIV_STEPS = COORD_W;
	localparam int DIV_LAT   = DIV_STEPS + 1;
	localparam int IDX_W     = 3;
	localparam int IN_W      = 6 * COORD_W;
	localparam int IN_BYTES  = (IN_W + 7) / 8;
	localparam int OUT_BYTES = 1;

	typedef enum logic [IDX_W-1:0] {
		REG_LOW_X  = 3'd0,
		REG_LOW_Y  = 3'd1,
		REG_LOW_Z  = 3'd2,
		REG_HIGH_X = 3'd3,
		REG_HIGH_Y = 3'd4,
		REG_HIGH_Z = 3'd5,
		REG_EPS    = 3'd6
	} reg_idx_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COORD_W:0]          num_mag_t;
	typedef logic [COORD_W-1:0]        den_mag_t;

	typedef struct packed {
		logic [AXES-1:0]  dir_neg;
		logic [AXES-1:0]  dir_zero;
		logic [AXES-1:0]  in_slab;
		logic [LANES-1:0] quo_neg;
	} side_t;

	localparam coord_t POS_LIM = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t NEG_LIM = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

>>> design/rbst_front.sv
// ----------------------------------------------------------------------------
// rbst_front
// Slab numerators, magnitudes and quotient signs for all six divisions.
// ----------------------------------------------------------------------------
module rbst_front (
	input  logic                                  clk,
	input  logic                                  en,
	input  rbst_pkg::coord_t                      lo [rbst_pkg::AXES],
	input  rbst_pkg::coord_t                      hi [rbst_pkg::AXES],
	input  rbst_pkg::coord_t                      org [rbst_pkg::AXES],
	input  rbst_pkg::coord_t                      dir [rbst_pkg::AXES],
	output rbst_pkg::num_mag_t                    num_s1 [rbst_pkg::LANES],
	output rbst_pkg::den_mag_t                    den_s1 [rbst_pkg::LANES],
	output rbst_pkg::side_t                       side_s1
);

	logic signed [rbst_pkg::COORD_W:0] diff [rbst_pkg::LANES];
	rbst_pkg::den_mag_t                dmag [rbst_pkg::AXES];
	rbst_pkg::side_t                   side;

	always_comb begin
		side = '0;
		for (int a = 0; a < rbst_pkg::AXES; a++) begin
			diff[2*a]   = {lo[a][rbst_pkg::COORD_W-1], lo[a]} -
			              {org[a][rbst_pkg::COORD_W-1], org[a]};
			diff[2*a+1] = {hi[a][rbst_pkg::COORD_W-1], hi[a]} -
			              {org[a][rbst_pkg::COORD_W-1], org[a]};
			dmag[a] = dir[a][rbst_pkg::COORD_W-1] ? rbst_pkg::COORD_W'(-dir[a]) : dir[a];
			side.dir_neg[a]  = dir[a][rbst_pkg::COORD_W-1];
			side.dir_zero[a] = (dir[a] == '0);
			side.in_slab[a]  = (lo[a] <= org[a]) && (org[a] <= hi[a]);
			for (int k = 0; k < 2; k++) begin
				side.quo_neg[2*a+k] = (diff[2*a+k] != '0) &&
				                      (diff[2*a+k][rbst_pkg::COORD_W] ^ dir[a][rbst_pkg::COORD_W-1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rbst_pkg::LANES; l++) begin
				num_s1[l] <= diff[l][rbst_pkg::COORD_W] ? -diff[l] : diff[l];
				den_s1[l] <= dmag[l/2];
			end
			side_s1 <= side;
		end
	end

endmodule

>>> design/rbst_div_lane.sv
// ----------------------------------------------------------------------------
// rbst_div_lane
// Pipelined restoring divider: (num << FRAC_W) / den, one quotient bit a stage,
// with a flag for quotients that do not fit COORD_W bits.
// ----------------------------------------------------------------------------
module rbst_div_lane (
	input  logic               clk,
	input  logic               en,
	input  rbst_pkg::num_mag_t num,
	input  rbst_pkg::den_mag_t den,
	output rbst_pkg::den_mag_t quo,
	output logic               sat
);

	localparam int CW = rbst_pkg::COORD_W;
	localparam int FW = rbst_pkg::FRAC_W;
	localparam int ST = rbst_pkg::DIV_STEPS;

	logic [CW-1:0] rem_s [ST+1];
	logic [CW-1:0] quo_s [ST+1];
	logic [CW-1:0] dvd_s [ST+1];
	logic [CW-1:0] den_s [ST+1];
	logic          sat_s [ST+1];
	logic [CW:0]   trial [ST];
	logic [ST-1:0] ge;

	always_comb begin
		for (int i = 0; i < ST; i++) begin
			trial[i] = {rem_s[i], dvd_s[i][CW-1]};
			ge[i]    = trial[i] >= {1'b0, den_s[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(num[CW:CW-FW]);
			sat_s[0] <= CW'(num[CW:CW-FW]) >= den;
			dvd_s[0] <= {num[CW-FW-1:0], {FW{1'b0}}};
			quo_s[0] <= '0;
			den_s[0] <= den;
			for (int i = 0; i < ST; i++) begin
				rem_s[i+1] <= ge[i] ? CW'(trial[i] - {1'b0, den_s[i]}) : trial[i][CW-1:0];
				quo_s[i+1] <= {quo_s[i][CW-2:0], ge[i]};
				dvd_s[i+1] <= {dvd_s[i][CW-2:0], 1'b0};
				den_s[i+1] <= den_s[i];
				sat_s[i+1] <= sat_s[i];
			end
		end
	end

	assign quo = quo_s[ST];
	assign sat = sat_s[ST];

endmodule

>>> design/rbst_back.sv
// ----------------------------------------------------------------------------
// rbst_back
// Saturate and sign the distances, pick entry and exit, reduce to the hit flag.
// ----------------------------------------------------------------------------
module rbst_back (
	input  logic                                clk,
	input  logic                                en,
	input  rbst_pkg::den_mag_t                  quo [rbst_pkg::LANES],
	input  logic [rbst_pkg::LANES-1:0]          sat,
	input  rbst_pkg::side_t                     side,
	input  logic [rbst_pkg::EPS_W-1:0]          eps,
	output logic                                hit_s3
);

	rbst_pkg::coord_t tdist [rbst_pkg::LANES];
	rbst_pkg::coord_t entry_s1 [rbst_pkg::AXES];
	rbst_pkg::coord_t exit_s1 [rbst_pkg::AXES];
	logic             ok_s1;
	rbst_pkg::coord_t near_s2, far_s2;
	logic             ok_s2;
	rbst_pkg::coord_t near_c, far_c;

	always_comb begin
		for (int l = 0; l < rbst_pkg::LANES; l++) begin
			if (side.quo_neg[l]) begin
				tdist[l] = (sat[l] || quo[l] > rbst_pkg::COORD_W'(rbst_pkg::NEG_LIM)) ?
				           rbst_pkg::NEG_LIM : rbst_pkg::COORD_W'(-quo[l]);
			end else begin
				tdist[l] = (sat[l] || quo[l] > rbst_pkg::COORD_W'(rbst_pkg::POS_LIM)) ?
				           rbst_pkg::POS_LIM : quo[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < rbst_pkg::AXES; a++) begin
				if (side.dir_zero[a]) begin
					entry_s1[a] <= rbst_pkg::NEG_LIM;
					exit_s1[a]  <= rbst_pkg::POS_LIM;
				end else if (side.dir_neg[a]) begin
					entry_s1[a] <= tdist[2*a+1];
					exit_s1[a]  <= tdist[2*a];
				end else begin
					entry_s1[a] <= tdist[2*a];
					exit_s1[a]  <= tdist[2*a+1];
				end
			end
			ok_s1 <= &(~side.dir_zero | side.in_slab);
		end
	end

	always_comb begin
		near_c = entry_s1[0];
		far_c  = exit_s1[0];
		for (int a = 1; a < rbst_pkg::AXES; a++) begin
			if (entry_s1[a] > near_c) near_c = entry_s1[a];
			if (exit_s1[a] < far_c) far_c = exit_s1[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s2 <= near_c;
			far_s2  <= far_c;
			ok_s2   <= ok_s1;
			hit_s3  <= ok_s2 && (near_s2 < far_s2) &&
			           (far_s2 > $signed({{(rbst_pkg::COORD_W-rbst_pkg::EPS_W){1'b0}}, eps}));
		end
	end

endmodule

>>> design/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box hit test by the slab method, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Write the box corners and the hit epsilon through cfg_we / cfg_index /
//   cfg_wdata while no ray is in flight. Rays enter on the s_ stream, one
//   item a cycle: tdata holds origin x, y, z then direction x, y, z, each a
//   32-bit signed Q16.16 word, origin x in the lowest bits. Each ray gives
//   one item on the m_ stream with the hit flag in tdata bit 0.
// Pipeline: one front stage, a 33-stage divider (one quotient bit a stage,
//   six lanes side by side), and three stages of selection and compare
//   ending in the output register.
// Throughput: one ray per cycle while not stalled, set by the fully pipelined lanes.
// Reset: clears all valid bits and loads the register defaults (box at
//   zero, epsilon 66).
// Stall: while an output item waits unaccepted the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rbst_pkg::IDX_W-1:0]           cfg_index,
	input  logic [rbst_pkg::COORD_W-1:0]         cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [8*rbst_pkg::IN_BYTES-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// hit, then zero fill
	output logic [8*rbst_pkg::OUT_BYTES-1:0]     m_tdata
);

	localparam int CW  = rbst_pkg::COORD_W;
	localparam int LAT = rbst_pkg::DIV_LAT + 4;

	rbst_pkg::coord_t           lo_q [rbst_pkg::AXES];
	rbst_pkg::coord_t           hi_q [rbst_pkg::AXES];
	logic [rbst_pkg::EPS_W-1:0] eps_q;
	logic [LAT-1:0]             vld_q;
	logic                       en;

	rbst_pkg::coord_t   org [rbst_pkg::AXES];
	rbst_pkg::coord_t   dir [rbst_pkg::AXES];
	rbst_pkg::num_mag_t num_s1 [rbst_pkg::LANES];
	rbst_pkg::den_mag_t den_s1 [rbst_pkg::LANES];
	rbst_pkg::side_t    side_s1;
	rbst_pkg::side_t    side_s [rbst_pkg::DIV_LAT];
	rbst_pkg::den_mag_t quo [rbst_pkg::LANES];
	logic [rbst_pkg::LANES-1:0] sat;
	logic               hit_s3;

	assign en       = m_tready || !m_tvalid;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = {{(8*rbst_pkg::OUT_BYTES-1){1'b0}}, hit_s3};

	always_comb begin
		for (int a = 0; a < rbst_pkg::AXES; a++) begin
			org[a] = s_tdata[a*CW +: CW];
			dir[a] = s_tdata[(a+rbst_pkg::AXES)*CW +: CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < rbst_pkg::AXES; a++) begin
				lo_q[a] <= '0;
				hi_q[a] <= '0;
			end
			eps_q <= rbst_pkg::EPS_W'(66);
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rbst_pkg::REG_LOW_X:  lo_q[0] <= cfg_wdata;
					rbst_pkg::REG_LOW_Y:  lo_q[1] <= cfg_wdata;
					rbst_pkg::REG_LOW_Z:  lo_q[2] <= cfg_wdata;
					rbst_pkg::REG_HIGH_X: hi_q[0] <= cfg_wdata;
					rbst_pkg::REG_HIGH_Y: hi_q[1] <= cfg_wdata;
					rbst_pkg::REG_HIGH_Z: hi_q[2] <= cfg_wdata;
					rbst_pkg::REG_EPS:    eps_q   <= cfg_wdata[rbst_pkg::EPS_W-1:0];
					default: ;
				endcase
			end
			if (en) vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	rbst_front u_front (
		.clk     (clk),
		.en      (en),
		.lo      (lo_q),
		.hi      (hi_q),
		.org     (org),
		.dir     (dir),
		.num_s1  (num_s1),
		.den_s1  (den_s1),
		.side_s1 (side_s1)
	);

	for (genvar l = 0; l < rbst_pkg::LANES; l++) begin : g_lane
		rbst_div_lane u_div (
			.clk (clk),
			.en  (en),
			.num (num_s1[l]),
			.den (den_s1[l]),
			.quo (quo[l]),
			.sat (sat[l])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_s1;
			for (int i = 1; i < rbst_pkg::DIV_LAT; i++) side_s[i] <= side_s[i-1];
		end
	end

	rbst_back u_back (
		.clk    (clk),
		.en     (en),
		.quo    (quo),
		.sat    (sat),
		.side   (side_s[rbst_pkg::DIV_LAT-1]),
		.eps    (eps_q),
		.hit_s3 (hit_s3)
	);

endmodule

>>> design/rbst_checker.sv
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks of the slab test stream behavior.
// ----------------------------------------------------------------------------
module rbst_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [8*rbst_pkg::OUT_BYTES-1:0]  m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("output item dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output item changed");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready) else $error("input taken during stall");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("input held while output empty");

	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[8*rbst_pkg::OUT_BYTES-1:1] == '0) else $error("fill bits set");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/ray_box_checker.sv
// ----------------------------------------------------------------------------
// ray_box_checker
// Watches the ray and result streams and the register port, computes the
// expected hit flag for every accepted ray with a slab-method model, and
// compares it with each accepted result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_box_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rbst_pkg::IDX_W-1:0]           cfg_index,
	input  logic [rbst_pkg::COORD_W-1:0]         cfg_wdata,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [8*rbst_pkg::IN_BYTES-1:0]      s_tdata,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [8*rbst_pkg::OUT_BYTES-1:0]     m_tdata,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   hits_seen,
	output int                                   rays_seen
);
	import rbst_pkg::*;

	coord_t           lo_c [AXES];
	coord_t           hi_c [AXES];
	logic [EPS_W-1:0] eps_c;
	logic             hit_queue [$];

	localparam longint POS_L = 64'sd2147483647;
	localparam longint NEG_L = -64'sd2147483648;

	function automatic longint slab_quotient(longint num, longint den);
		logic    neg;
		longint  an, ad, q, r, lim, mag;
		neg = (num < 0) != (den < 0);
		an  = num < 0 ? -num : num;
		ad  = den < 0 ? -den : den;
		lim = neg ? -NEG_L : POS_L;
		q   = an / ad;
		r   = an % ad;
		if (q > (lim >>> FRAC_W))
			mag = lim;
		else begin
			mag = (q <<< FRAC_W) + ((r <<< FRAC_W) / ad);
			if (mag > lim)
				mag = lim;
		end
		return neg ? -mag : mag;
	endfunction

	function automatic logic ray_hits(logic [8*IN_BYTES-1:0] d);
		longint near_d, far_d, lo, hi, o, dv, en, ex;
		logic   ok;
		ok     = 1'b1;
		near_d = NEG_L;
		far_d  = POS_L;
		for (int a = 0; a < AXES; a++) begin
			lo = lo_c[a];
			hi = hi_c[a];
			o  = coord_t'(d[a*COORD_W +: COORD_W]);
			dv = coord_t'(d[(a+3)*COORD_W +: COORD_W]);
			if (dv == 0) begin
				en = NEG_L;
				ex = POS_L;
				if (!(lo <= o && o <= hi))
					ok = 1'b0;
			end else if (dv > 0) begin
				en = slab_quotient(lo - o, dv);
				ex = slab_quotient(hi - o, dv);
			end else begin
				en = slab_quotient(hi - o, dv);
				ex = slab_quotient(lo - o, dv);
			end
			if (en > near_d) near_d = en;
			if (ex < far_d) far_d = ex;
		end
		return ok && near_d < far_d && far_d > longint'(eps_c);
	endfunction

	assign pending = hit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				lo_c[a] = '0;
				hi_c[a] = '0;
			end
			eps_c      = 16'd66;
			fail_count = 0;
			hits_seen  = 0;
			rays_seen  = 0;
			hit_queue.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_LOW_X:  lo_c[0] = cfg_wdata;
					REG_LOW_Y:  lo_c[1] = cfg_wdata;
					REG_LOW_Z:  lo_c[2] = cfg_wdata;
					REG_HIGH_X: hi_c[0] = cfg_wdata;
					REG_HIGH_Y: hi_c[1] = cfg_wdata;
					REG_HIGH_Z: hi_c[2] = cfg_wdata;
					REG_EPS:    eps_c   = cfg_wdata[EPS_W-1:0];
					default:    ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (hit_queue.size() == 0) begin
					$error("unexpected result item, hit=%0b", m_tdata[0]);
					fail_count++;
				end else begin
					want = hit_queue.pop_front();
					if (m_tdata[0] !== want) begin
						$error("hit mismatch: expected %0b, actual %0b", want, m_tdata[0]);
						fail_count++;
					end
					if (want) hits_seen++;
				end
			end
			if (s_tvalid && s_tready) begin
				hit_queue.push_back(ray_hits(s_tdata));
				rays_seen++;
			end
		end
	end
endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives rays and box settings into the slab hit test with random gaps and
// back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import rbst_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [COORD_W-1:0]      cfg_wdata = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [8*IN_BYTES-1:0]   s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [8*OUT_BYTES-1:0]  m_tdata;
	int                      fail_count, pending, hits_seen, rays_seen;
	bit                      hold_sink = 1'b0;
	bit                      sink_free = 1'b1;

	ray_box_slab_test uut (.*);

	ray_box_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic coord_t q16(int whole);
		return coord_t'(whole <<< FRAC_W);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom());
			1: return NEG_LIM;
			2: return POS_LIM;
			3: return coord_t'($urandom_range(0, 65536)) - 32768;
			default: return coord_t'($signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000);
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, coord_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic set_box(coord_t lx, coord_t ly, coord_t lz,
			coord_t hx, coord_t hy, coord_t hz, logic [EPS_W-1:0] eps);
		write_reg(REG_LOW_X, lx);
		write_reg(REG_LOW_Y, ly);
		write_reg(REG_LOW_Z, lz);
		write_reg(REG_HIGH_X, hx);
		write_reg(REG_HIGH_Y, hy);
		write_reg(REG_HIGH_Z, hz);
		write_reg(REG_EPS, coord_t'(eps));
		cfg_we <= 1'b0;
	endtask

	task automatic send_ray(coord_t ox, coord_t oy, coord_t oz,
			coord_t dx, coord_t dy, coord_t dz, bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {dz, dy, dx, oz, oy, ox};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DIV_LAT + 8) @(negedge clk);
	endtask

	task automatic random_ray(bit no_gap);
		coord_t o [3], d [3];
		for (int a = 0; a < 3; a++) begin
			o[a] = rand_coord();
			d[a] = ($urandom_range(0, 9) == 0) ? coord_t'(0) : rand_coord();
		end
		if ($urandom_range(0, 2) != 0) begin
			o[0] = q16(-4) + coord_t'($urandom_range(0, 8 << FRAC_W));
			o[1] = q16(-4) + coord_t'($urandom_range(0, 8 << FRAC_W));
			o[2] = q16(-4) + coord_t'($urandom_range(0, 8 << FRAC_W));
		end
		send_ray(o[0], o[1], o[2], d[0], d[1], d[2], no_gap);
	endtask

	always @(negedge clk) begin
		int g;
		if (hold_sink) begin
			m_tready <= 1'b0;
		end else if (!sink_free && $urandom_range(0, 1)) begin
			g = gap_len();
			if (g == 0) m_tready <= 1'b1;
			else begin
				m_tready <= 1'b0;
				repeat (g) @(negedge clk);
				m_tready <= 1'b1;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset box at origin, zero size
		send_ray(0, 0, 0, 0, 0, 0, 1);
		send_ray(0, 0, 0, q16(1), q16(1), q16(1), 1);
		drain();

		set_box(q16(-1), q16(-1), q16(-1), q16(1), q16(1), q16(1), 16'd0);
		send_ray(q16(-5), 0, 0, q16(1), 0, 0, 1);
		send_ray(q16(5), 0, 0, q16(1), 0, 0, 1);
		send_ray(q16(5), 0, 0, q16(-1), 0, 0, 1);
		send_ray(0, 0, 0, 0, 0, 0, 1);
		send_ray(q16(1), q16(1), q16(1), 0, 0, 0, 1);
		send_ray(q16(2), 0, 0, 0, q16(1), 0, 1);
		send_ray(NEG_LIM, 0, 0, 32'sd1, 0, 0, 1);
		send_ray(POS_LIM, POS_LIM, POS_LIM, NEG_LIM, NEG_LIM, NEG_LIM, 1);
		send_ray(NEG_LIM, NEG_LIM, NEG_LIM, POS_LIM, POS_LIM, POS_LIM, 1);
		send_ray(q16(-3), q16(-3), q16(-3), 32'sd1, 32'sd1, 32'sd1, 1);
		send_ray(q16(-1), q16(-1), q16(-1), 32'sd1, 32'sd1, 32'sd1, 1);
		send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		send_ray(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1);
		drain();

		// entry distance at and just above epsilon
		set_box(NEG_LIM, NEG_LIM, NEG_LIM, 32'sd0, 32'sd0, 32'sd0, 16'hFFFF);
		send_ray(32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF,
			q16(-1), q16(-1), q16(-1), 1);
		send_ray(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
			q16(-1), q16(-1), q16(-1), 1);
		drain();

		// inverted box and full-range box
		set_box(q16(2), q16(2), q16(2), q16(-2), q16(-2), q16(-2), 16'd66);
		send_ray(0, 0, 0, q16(1), q16(1), q16(1), 1);
		send_ray(0, 0, 0, 0, 0, 0, 1);
		drain();
		set_box(NEG_LIM, NEG_LIM, NEG_LIM, POS_LIM, POS_LIM, POS_LIM, 16'd0);
		send_ray(NEG_LIM, POS_LIM, 0, 0, 0, 0, 1);
		send_ray(NEG_LIM, NEG_LIM, NEG_LIM, POS_LIM, 32'sd1, NEG_LIM, 1);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5)
				set_box(NEG_LIM, NEG_LIM, NEG_LIM, POS_LIM, POS_LIM, POS_LIM, 16'hFFFF);
			else
				set_box(rand_coord() >>> 2, -q16($urandom_range(0, 4)),
					-q16($urandom_range(0, 4)), q16($urandom_range(0, 4)),
					q16($urandom_range(0, 4)), rand_coord() >>> 2,
					16'($urandom()));
			sink_free = (phase % 2) == 0;
			for (int i = 0; i < 105; i++) begin
				if (phase == 2 && i == 10) begin
					fork
						begin
							hold_sink = 1'b1;
							repeat (150) @(negedge clk);
							hold_sink = 1'b0;
						end
					join_none
				end
				random_ray(phase == 2 && i < 60);
			end
			drain();
		end

		$display("rays sent %0d, hits %0d, over fixed and random boxes", rays_seen, hits_seen);
		$display("covered zero directions, saturated distances, inverted boxes, stalls");
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> files.f
design/rbst_pkg.sv
design/rbst_front.sv
design/rbst_div_lane.sv
design/rbst_back.sv
design/ray_box_slab_test.sv
design/rbst_checker.sv
tb/ray_box_checker.sv
tb/testbench.sv
